// ===== hw/rtl/egs_pkg.sv =====
package egs_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCUS_END = 1'd1;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Interval bounds in Q4.28 and fixed-point constants
  localparam logic signed [31:0] UMIN_Q28 = -32'sd53687091;
  localparam logic signed [31:0] UMAX_Q28 = 32'sd322122547;
  localparam logic signed [32:0] ONE_Q28  = 33'sd268435456;
  localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] ONE_Q62  = 64'h4000_0000_0000_0000;
  localparam logic [63:0] LN2_Q56  = 64'h00B1_7217_F7D1_CF7A;
  localparam logic [63:0] QPIN     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] OUT_MIN = -64'sh0000_8000_0000_0000;

  // Configuration seen by front and back
  typedef struct packed {
    logic [31:0] exponent;
    logic        focus_end;
  } egs_cfg_t;

  // One classified request as queued between front and back
  typedef struct packed {
    logic               ident;
    logic signed [32:0] up;
    logic signed [31:0] uc;
    logic signed [33:0] du;
  } egs_item_t;

  // Clamp to the signed 48-bit range; the top bit flags a clamp
  function automatic logic [48:0] clamp48(input logic [63:0] v);
    logic [48:0] res;
    if ($signed(v) > OUT_MAX) begin
      res = {1'b1, OUT_MAX[47:0]};
    end else if ($signed(v) < OUT_MIN) begin
      res = {1'b1, OUT_MIN[47:0]};
    end else begin
      res = {1'b0, v[47:0]};
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/exponential_grid_stretch_eval.sv =====
// Channel   Direction  Handshake          Payload
// input     in         push / full        uniform_value
// result    out        empty / pop        stretched_value, slope, curvature, saturated
// config    in         wr_en (no wait)    wr_index, wr_data
//
// With exponent 0 a request goes straight to the result stage in the back end;
// otherwise it runs the Taylor series on the shared 32x32 multiplier,
// the 8-bit-a-cycle divide by n and the 1-bit-a-cycle wide divider.
// The front end accepts one request a cycle until the QUEUE_DEPTH queue fills.
// A finished result waits in the output register while the next one is worked.
// Synchronous active-high reset empties the queue, clears the configuration and returns the back end to idle.
module exponential_grid_stretch_eval #(
  parameter int QUEUE_DEPTH = egs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [31:0]                   uniform_value,
  output logic                          empty,
  input  logic                          pop,
  output logic [47:0]                   stretched_value,
  output logic [47:0]                   slope,
  output logic [47:0]                   curvature,
  output logic                          saturated,
  input  logic                          wr_en,
  input  logic [egs_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [31:0]                   wr_data
);
  import egs_pkg::*;

  egs_cfg_t  cfg;
  egs_item_t f_item;
  egs_item_t b_item;
  logic      f_wr;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.exponent  <= '0;
      cfg.focus_end <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_EXPONENT:  cfg.exponent  <= wr_data;
        CFG_FOCUS_END: cfg.focus_end <= wr_data[0];
      endcase
    end
  end

  egs_front u_front (
    .push          (push),
    .uniform_value (uniform_value),
    .cfg           (cfg),
    .q_full        (q_full),
    .full          (full),
    .q_wr          (f_wr),
    .q_item        (f_item)
  );

  egs_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (f_wr),
    .wr_item (f_item),
    .rd      (q_pop),
    .rd_item (b_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  egs_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_empty         (q_empty),
    .q_item          (b_item),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .stretched_value (stretched_value),
    .slope           (slope),
    .curvature       (curvature),
    .saturated       (saturated)
  );

endmodule

// ===== hw/rtl/egs_fifo.sv =====
module egs_fifo #(
  parameter int DEPTH = egs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  egs_pkg::egs_item_t  wr_item,
  input  logic                rd,
  output egs_pkg::egs_item_t  rd_item,
  output logic                full,
  output logic                empty
);
  import egs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  egs_item_t          mem [DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_item = mem[rptr];

  // Store the request at the write pointer
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_item;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr |-> (!full || rd))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

// ===== hw/rtl/egs_front.sv =====
module egs_front (
  input  logic               push,
  input  logic [31:0]        uniform_value,
  input  egs_pkg::egs_cfg_t  cfg,
  input  logic               q_full,
  output logic               full,
  output logic               q_wr,
  output egs_pkg::egs_item_t q_item
);
  import egs_pkg::*;

  logic signed [32:0] u_ext;
  logic signed [32:0] up;
  logic signed [31:0] uc;

  // Flip towards the focused end, then clamp into the exponential interval
  always_comb begin
    u_ext = {uniform_value[31], uniform_value};
    up    = cfg.focus_end ? 33'(ONE_Q28 - u_ext) : u_ext;
    if (up < 33'(UMIN_Q28)) begin
      uc = UMIN_Q28;
    end else if (up > 33'(UMAX_Q28)) begin
      uc = UMAX_Q28;
    end else begin
      uc = up[31:0];
    end
  end

  // Classify and hand the request on
  assign q_item.ident = (cfg.exponent == '0);
  assign q_item.up    = up;
  assign q_item.uc    = uc;
  assign q_item.du    = 34'({up[32], up} - {{2{uc[31]}}, uc});
  assign full         = q_full;
  assign q_wr         = push && !q_full;

endmodule

// ===== hw/rtl/egs_back.sv =====
module egs_back (
  input  logic               clk,
  input  logic               rst,
  input  egs_pkg::egs_cfg_t  cfg,
  input  logic               q_empty,
  input  egs_pkg::egs_item_t q_item,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic [47:0]        stretched_value,
  output logic [47:0]        slope,
  output logic [47:0]        curvature,
  output logic               saturated
);
  import egs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_RED, S_RFIX, S_TERM, S_TDIV, S_NDIV, S_EXPD, S_PU, S_PREP,
    S_DIV, S_SQ, S_DSX, S_POST, S_LIN, S_CURV, S_FIN, S_MUL
  } state_t;

  state_t state;
  state_t ret;

  // Request
  logic signed [31:0] it_uc;
  logic signed [33:0] it_du;

  // Range reduction and series
  logic               p_neg;
  logic [63:0]        rem;
  logic [5:0]         qf;
  logic [2:0]         j;
  logic               which;
  logic signed [7:0]  k;
  logic [63:0]        rr;
  logic [63:0]        term;
  logic [63:0]        sum;
  logic [6:0]         n;
  logic [63:0]        nword;
  logic [6:0]         nrem;
  logic [2:0]         dcnt;
  logic signed [7:0]  ka;
  logic signed [7:0]  ku;
  logic [63:0]        ma;
  logic [63:0]        mu;

  // Shared multiplier
  logic [63:0]        mul_a;
  logic [63:0]        mul_b;
  logic [127:0]       acc;
  logic [63:0]        pp;
  logic [1:0]         pp_sh;
  logic [2:0]         mcnt;

  // Wide divider
  logic [127:0]       dword;
  logic [63:0]        drem;
  logic [63:0]        dq;
  logic [63:0]        dden;
  logic [7:0]         dbig;
  logic               dsel;

  // Core values
  logic [63:0]        eu;
  logic               neg;
  logic [63:0]        s;
  logic [63:0]        ds;
  logic [63:0]        d2;
  logic               sat;

  // Result register
  logic               res_valid;

  // Combinational helpers
  logic [63:0]        cand;
  logic [6:0]         nd_rem;
  logic [63:0]        nd_word;
  logic [64:0]        drem_sh;
  logic               dge;
  logic [63:0]        drem_n;
  logic [31:0]        a_part;
  logic [31:0]        b_part;
  logic signed [7:0]  kmax_c;
  logic signed [7:0]  shv_c;
  logic [7:0]         so_c;
  logic [7:0]         sa_c;
  logic [7:0]         su_c;
  logic [63:0]        one_c;
  logic [63:0]        ea_c;
  logic [63:0]        eu_c;
  logic [63:0]        s_f;
  logic [63:0]        d2_f;
  logic [48:0]        s_cl;
  logic [48:0]        ds_cl;
  logic [48:0]        d2_cl;
  logic [63:0]        uc_mag;
  logic [63:0]        du_mag;

  assign q_pop  = (state == S_IDLE) && !q_empty;
  assign empty  = !res_valid;
  assign cand   = LN2_Q56 << j;
  assign a_part = mcnt[0] ? mul_a[63:32] : mul_a[31:0];
  assign b_part = mcnt[1] ? mul_b[63:32] : mul_b[31:0];
  assign uc_mag = it_uc[31] ? 64'(-{{32{it_uc[31]}}, it_uc}) : {32'd0, it_uc};
  assign du_mag = it_du[33] ? 64'(-{{30{it_du[33]}}, it_du}) : {30'd0, it_du};

  // Divide the series term by n, eight quotient bits a cycle
  always_comb begin
    nd_rem  = nrem;
    nd_word = nword;
    for (int b = 0; b < 8; b++) begin
      nd_rem  = {nd_rem[5:0], nd_word[63]};
      nd_word = {nd_word[62:0], 1'b0};
      if (nd_rem >= n) begin
        nd_rem     = nd_rem - n;
        nd_word[0] = 1'b1;
      end
    end
  end

  // One restoring step of the wide divider
  always_comb begin
    drem_sh = {drem, dword[127]};
    dge     = (drem_sh >= {1'b0, dden});
    drem_n  = dge ? 64'(drem_sh - {1'b0, dden}) : drem_sh[63:0];
  end

  // Align both exponentials to a common scale
  always_comb begin
    kmax_c = (ka > ku) ? ka : ku;
    if (kmax_c < 0) begin
      kmax_c = '0;
    end
    shv_c = kmax_c + 8'sd1;
    so_c  = 8'(8'sd62 - shv_c);
    sa_c  = 8'(shv_c - ka);
    su_c  = 8'(shv_c - ku);
    one_c = 64'd1 << so_c;
    ea_c  = ma >> sa_c;
    eu_c  = mu >> su_c;
  end

  // Mirror for the focused end and clamp
  always_comb begin
    s_f   = cfg.focus_end ? ONE_Q32 - s : s;
    d2_f  = cfg.focus_end ? 64'd0 - d2 : d2;
    s_cl  = clamp48(s_f);
    ds_cl = clamp48(ds);
    d2_cl = clamp48(d2_f);
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (pop && res_valid && state != S_FIN) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            it_uc <= q_item.uc;
            it_du <= q_item.du;
            sat   <= 1'b0;
            if (q_item.ident) begin
              s     <= {{31{q_item.up[32]}}, q_item.up} << 4;
              ds    <= ONE_Q32;
              d2    <= '0;
              state <= S_FIN;
            end else begin
              p_neg <= 1'b0;
              rem   <= {4'd0, cfg.exponent, 28'd0};
              j     <= 3'd5;
              qf    <= '0;
              which <= 1'b0;
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          if (rem >= cand) begin
            rem   <= rem - cand;
            qf[j] <= 1'b1;
          end
          if (j == 3'd0) begin
            state <= S_RFIX;
          end else begin
            j <= j - 1'b1;
          end
        end
        S_RFIX: begin
          if (!p_neg) begin
            k  <= {2'd0, qf};
            rr <= rem << 6;
          end else if (rem == '0) begin
            k  <= -$signed({2'd0, qf});
            rr <= '0;
          end else begin
            k  <= -$signed({2'd0, qf} + 8'd1);
            rr <= (LN2_Q56 - rem) << 6;
          end
          sum   <= ONE_Q62;
          term  <= ONE_Q62;
          n     <= 7'd1;
          state <= S_TERM;
        end
        S_TERM: begin
          if (n == 7'd64 || term == '0) begin
            state <= S_EXPD;
          end else begin
            mul_a <= term;
            mul_b <= rr;
            mcnt  <= '0;
            acc   <= '0;
            ret   <= S_TDIV;
            state <= S_MUL;
          end
        end
        S_TDIV: begin
          nword <= acc[125:62];
          nrem  <= '0;
          dcnt  <= '0;
          state <= S_NDIV;
        end
        S_NDIV: begin
          nword <= nd_word;
          nrem  <= nd_rem;
          dcnt  <= dcnt + 1'b1;
          if (dcnt == 3'd7) begin
            term  <= nd_word;
            sum   <= sum + nd_word;
            n     <= n + 1'b1;
            state <= S_TERM;
          end
        end
        S_EXPD: begin
          if (!which) begin
            ka    <= k;
            ma    <= sum;
            which <= 1'b1;
            mul_a <= {32'd0, cfg.exponent};
            mul_b <= uc_mag;
            mcnt  <= '0;
            acc   <= '0;
            ret   <= S_PU;
            state <= S_MUL;
          end else begin
            ku    <= k;
            mu    <= sum;
            state <= S_PREP;
          end
        end
        S_PU: begin
          p_neg <= it_uc[31];
          rem   <= acc[63:0];
          j     <= 3'd5;
          qf    <= '0;
          state <= S_RED;
        end
        S_PREP: begin
          dden  <= (ea_c > one_c) ? ea_c - one_c : 64'd1;
          eu    <= eu_c;
          neg   <= (eu_c < one_c);
          dword <= {((eu_c < one_c) ? one_c - eu_c : eu_c - one_c), 64'd0};
          drem  <= '0;
          dq    <= '0;
          dbig  <= 8'd96;
          dsel  <= 1'b0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (dq[63:62] != 2'b00) begin
            dq    <= QPIN;
            sat   <= 1'b1;
            state <= dsel ? S_POST : S_SQ;
          end else begin
            dword <= {dword[126:0], 1'b0};
            drem  <= drem_n;
            dq    <= {dq[62:0], dge};
            dbig  <= dbig - 1'b1;
            if (dbig == 8'd1) begin
              state <= dsel ? S_POST : S_SQ;
            end
          end
        end
        S_SQ: begin
          s     <= neg ? 64'd0 - dq : dq;
          mul_a <= {32'd0, cfg.exponent};
          mul_b <= eu;
          mcnt  <= '0;
          acc   <= '0;
          ret   <= S_DSX;
          state <= S_MUL;
        end
        S_DSX: begin
          dword <= acc;
          drem  <= '0;
          dq    <= '0;
          dbig  <= 8'd152;
          dsel  <= 1'b1;
          state <= S_DIV;
        end
        S_POST: begin
          ds    <= {20'd0, dq[63:20]};
          mul_b <= dq;
          mcnt  <= '0;
          acc   <= '0;
          state <= S_MUL;
          if (it_du != '0) begin
            mul_a <= du_mag;
            ret   <= S_LIN;
          end else begin
            mul_a <= {32'd0, cfg.exponent};
            ret   <= S_CURV;
          end
        end
        S_LIN: begin
          s     <= it_du[33] ? s - acc[111:48] : s + acc[111:48];
          d2    <= '0;
          state <= S_FIN;
        end
        S_CURV: begin
          d2    <= acc[111:48];
          state <= S_FIN;
        end
        S_FIN: begin
          if (!res_valid || pop) begin
            stretched_value <= s_cl[47:0];
            slope           <= ds_cl[47:0];
            curvature       <= d2_cl[47:0];
            saturated       <= sat | s_cl[48] | ds_cl[48] | d2_cl[48];
            res_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        S_MUL: begin
          if (mcnt != 3'd4) begin
            pp    <= a_part * b_part;
            pp_sh <= 2'(mcnt[0] + mcnt[1]);
          end
          if (mcnt != 3'd0) begin
            acc <= acc + ({64'd0, pp} << {pp_sh, 5'd0});
          end
          if (mcnt == 3'd4) begin
            state <= ret;
          end else begin
            mcnt <= mcnt + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_count: assert property (@(posedge clk) disable iff (rst) (state == S_DIV) |-> (dbig != '0))
    else $error("divider running with no steps left");
  a_ndiv_range: assert property (@(posedge clk) disable iff (rst)
      (state == S_NDIV) |-> (n >= 7'd1 && n <= 7'd63))
    else $error("series divisor out of range");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
      (state == S_FIN && res_valid && !pop) |=> (state == S_FIN))
    else $error("result register overwritten before it was taken");
  a_start: assert property (@(posedge clk) disable iff (rst)
      (state == S_IDLE && !q_empty) |=> (state == S_RED || state == S_FIN))
    else $error("request taken without starting work");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import egs_pkg::*;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [31:0] uniform_value;
  logic        empty;
  logic        pop;
  logic [47:0] stretched_value;
  logic [47:0] slope;
  logic [47:0] curvature;
  logic        saturated;
  logic        wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [31:0] wr_data;

  typedef struct {
    logic [47:0] s;
    logic [47:0] ds;
    logic [47:0] d2;
    logic        sat;
  } stretch_res_t;

  typedef struct {
    int          k;
    logic [63:0] m;
  } exp_parts_t;

  exponential_grid_stretch_eval uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .uniform_value(uniform_value),
    .empty(empty), .pop(pop), .stretched_value(stretched_value), .slope(slope),
    .curvature(curvature), .saturated(saturated), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data)
  );

  // Shadow copy of the configuration
  logic [31:0] alpha_cfg;
  logic        focus_cfg;

  logic [31:0]  coord_pending_q[$];
  stretch_res_t stretch_due_q[$];
  int           err_cnt;
  int           req_cnt;
  int           res_cnt;
  bit           no_idle;
  int           hold_reqs;
  int           hold_seen;
  int           hold_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // floor(a*b / 2^s), truncated to 64 bits
  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod >> s);
  endfunction

  // Restoring divide of hi:lo * 2^f by d; top bit flags a pinned quotient
  function automatic logic [64:0] wide_div(logic [63:0] hi, logic [63:0] lo,
                                           logic [63:0] d, int f);
    logic [63:0] q;
    logic [63:0] rem;
    logic        bt;
    q = 0;
    rem = 0;
    if (d == 0) d = 1;
    for (int i = 0; i < 128 + f; i++) begin
      bt = 1'b0;
      if (i < 64) bt = hi[63-i];
      else if (i < 128) bt = lo[127-i];
      rem = {rem[62:0], bt};
      if (q >= 64'h4000_0000_0000_0000) return {1'b1, QPIN};
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q[0] = 1'b1;
      end
    end
    return {1'b0, q};
  endfunction

  // e^(p/2^56) as mantissa Q62 times 2^k
  function automatic exp_parts_t exp_reduce(longint p);
    exp_parts_t res;
    logic [63:0] q, r, term, sum;
    if (p >= 0) begin
      q = 64'(p) / LN2_Q56;
      r = 64'(p) - q * LN2_Q56;
      res.k = int'(q);
    end else begin
      q = (64'(-p) + LN2_Q56 - 1) / LN2_Q56;
      r = q * LN2_Q56 - 64'(-p);
      res.k = -int'(q);
    end
    r = r << 6;
    sum = ONE_Q62;
    term = ONE_Q62;
    for (int n = 1; n < 64 && term != 0; n++) begin
      term = mul_shr(term, r, 62) / 64'(n);
      sum = sum + term;
    end
    res.m = sum;
    return res;
  endfunction

  function automatic logic [47:0] sat48(longint v, inout logic sat);
    if (v > OUT_MAX) begin
      sat = 1'b1;
      return OUT_MAX[47:0];
    end
    if (v < OUT_MIN) begin
      sat = 1'b1;
      return OUT_MIN[47:0];
    end
    return v[47:0];
  endfunction

  // Predict the stretched coordinate and its derivatives for one request
  function automatic stretch_res_t stretch_predict(logic [31:0] uv);
    stretch_res_t res;
    exp_parts_t pa, pu;
    longint u, up, uc, du, s, ds, d2;
    logic [63:0] a, one, ea, eu, den, mag, sq, hi, dsx, t;
    logic [127:0] prod;
    logic [64:0] dq;
    logic sat, neg;
    int sh;
    sat = 1'b0;
    u = longint'($signed(uv));
    up = focus_cfg ? (longint'(ONE_Q28) - u) : u;
    if (alpha_cfg == 0) begin
      s = up * 16;
      ds = longint'(ONE_Q32);
      d2 = 0;
    end else begin
      a = 64'(alpha_cfg);
      uc = up < longint'(UMIN_Q28) ? longint'(UMIN_Q28) :
           (up > longint'(UMAX_Q28) ? longint'(UMAX_Q28) : up);
      pa = exp_reduce(longint'(a << 28));
      pu = exp_reduce(longint'(a) * uc);
      sh = pa.k > pu.k ? pa.k : pu.k;
      if (sh < 0) sh = 0;
      sh = sh + 1;
      one = 64'd1 << (62 - sh);
      ea = pa.m >> (sh - pa.k);
      eu = pu.m >> (sh - pu.k);
      den = ea > one ? ea - one : 64'd1;
      neg = eu < one;
      mag = neg ? one - eu : eu - one;
      dq = wide_div(64'd0, mag, den, 32);
      sat = sat | dq[64];
      sq = dq[63:0];
      s = neg ? -longint'(sq) : longint'(sq);
      prod = {64'd0, a} * {64'd0, eu};
      hi = prod[127:64];
      dq = wide_div(hi, prod[63:0], den, 24);
      sat = sat | dq[64];
      dsx = dq[63:0];
      ds = longint'(dsx >> 20);
      du = up - uc;
      if (du != 0) begin
        t = mul_shr(64'(du < 0 ? -du : du), dsx, 48);
        s = du < 0 ? s - longint'(t) : s + longint'(t);
        d2 = 0;
      end else begin
        d2 = longint'(mul_shr(a, dsx, 48));
      end
    end
    if (focus_cfg) begin
      s = longint'(ONE_Q32) - s;
      d2 = -d2;
    end
    res.s = sat48(s, sat);
    res.ds = sat48(ds, sat);
    res.d2 = sat48(d2, sat);
    res.sat = sat;
    return res;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 29);
  endfunction

  // Driver: offer pending coordinates, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      uniform_value <= '0;
    end else begin
      if (push && !full) begin
        stretch_due_q.push_back(stretch_predict(uniform_value));
        req_cnt++;
      end
      if (!push || !full) begin
        if (coord_pending_q.size() > 0 && !idle_now()) begin
          uniform_value <= coord_pending_q.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    stretch_res_t want;
    if (rst) begin
      pop <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else begin
      if (pop && !empty) begin
        res_cnt++;
        if (stretch_due_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result s=%h", $time, stretched_value);
        end else begin
          want = stretch_due_q.pop_front();
          if (stretched_value !== want.s) begin
            err_cnt++;
            $display("%0t: stretched_value exp %h got %h", $time, want.s, stretched_value);
          end
          if (slope !== want.ds) begin
            err_cnt++;
            $display("%0t: slope exp %h got %h", $time, want.ds, slope);
          end
          if (curvature !== want.d2) begin
            err_cnt++;
            $display("%0t: curvature exp %h got %h", $time, want.d2, curvature);
          end
          if (saturated !== want.sat) begin
            err_cnt++;
            $display("%0t: saturated exp %b got %b", $time, want.sat, saturated);
          end
        end
      end
      // Hold off the receiver for a long stretch on request
      if (hold_seen != hold_reqs) begin
        hold_seen <= hold_reqs;
        hold_left <= 400;
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else begin
        pop <= !idle_now();
      end
    end
  end

  task automatic write_cfg(logic [31:0] alpha, logic focus);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= CFG_EXPONENT;
    wr_data <= alpha;
    @(posedge clk);
    wr_index <= CFG_FOCUS_END;
    wr_data <= {31'd0, focus};
    @(posedge clk);
    wr_en <= 1'b0;
    alpha_cfg = alpha;
    focus_cfg = focus;
  endtask

  task automatic drain();
    while (coord_pending_q.size() > 0 || push || stretch_due_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    int sel;
    sel = $urandom_range(3);
    case (sel)
      0: return $urandom();
      1: return 32'($urandom_range(UMIN_Q28 + 32'sd60000000, 32'd0)) - 32'd60000000;
      2: return $urandom_range(32'd400000000, 32'd0);
      default: return (sel[0] ? UMIN_Q28 : UMAX_Q28) + 32'($urandom_range(8)) - 32'd4;
    endcase
  endfunction

  task automatic load_directed();
    logic [31:0] pts[14];
    pts = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, UMIN_Q28, UMAX_Q28, UMIN_Q28 - 1,
            UMAX_Q28 + 1, ONE_Q28[31:0], 32'd1, 32'hFFFF_FFFF, 32'h0800_0000,
            32'hAAAA_AAAA, 32'h5555_5555, 32'h1000_0000};
    foreach (pts[i]) coord_pending_q.push_back(pts[i]);
  endtask

  initial begin
    logic [31:0] alphas[8];
    logic        focuses[8];
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    uniform_value = '0;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    alpha_cfg = 0;
    focus_cfg = 0;
    err_cnt = 0;
    req_cnt = 0;
    res_cnt = 0;
    no_idle = 0;
    hold_reqs = 0;
    alphas = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h3000_0000, 32'd0, 32'h1000_0000,
               32'hFFFF_FFFF, $urandom()};
    focuses = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed corners under identity and steep maps, both focus ends
    write_cfg(32'd0, 1'b0);
    load_directed();
    drain();
    write_cfg(32'hFFFF_FFFF, 1'b1);
    load_directed();
    drain();

    // Random phases across settings; pause for every result between them
    foreach (alphas[p]) begin
      write_cfg(alphas[p], focuses[p]);
      no_idle = (p == 5);
      if (p == 4) hold_reqs++;
      repeat (240) coord_pending_q.push_back(rand_coord());
      drain();
    end
    no_idle = 0;
    repeat (2000) @(posedge clk);
    $display("Covered %0d requests and %0d results over identity, shallow and steep maps,",
             req_cnt, res_cnt);
    $display("both focus ends, bound corners, back-pressure and idle-free stretches.");
    if (err_cnt == 0 && stretch_due_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/egs_pkg.sv
hw/rtl/egs_fifo.sv
hw/rtl/egs_front.sv
hw/rtl/egs_back.sv
hw/rtl/exponential_grid_stretch_eval.sv
tb/sv/tb_top.sv
